// ===== src/icmpd_pkg.sv =====
package icmpd_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int SLOT_W      = 5;

    localparam logic [7:0] PROTO_ICMP        = 8'd1;
    localparam logic [7:0] KIND_ECHO_REQUEST = 8'd8;

    typedef enum logic [1:0] {
        OUT_ACCEPT  = 2'd0,
        OUT_HIT     = 2'd1,
        OUT_APPEND  = 2'd2,
        OUT_REPLACE = 2'd3
    } t_outcome;

    // One row of the source table.
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] drops;
        logic [31:0] stamp;
    } t_entry;

endpackage

// ===== src/icmpd_entry_ram.sv =====
module icmpd_entry_ram #(
    parameter int DEPTH = icmpd_pkg::ENTRIES_DEF,
    parameter int IW    = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_idx,
    input  icmpd_pkg::t_entry i_wr_data,
    input  logic [IW-1:0]     i_rd_idx,
    output icmpd_pkg::t_entry o_rd_data
);
    import icmpd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/icmp_echo_drop_source_lru_table_unit.sv =====
// An accepted packet passes from idle through the done state to the output register; a dropped
// echo request first goes through the table scan (skipped on an empty table) and the row write.
// Throughput: one item at a time; the scan reads one table row per cycle through the
// single read port of the table memory, which also finds the oldest stamp in the same pass.
// Reset clears the fill count, the running total and all handshake state at once; the
// table memory is not cleared, since rows at or above the fill count are never compared.
module icmp_echo_drop_source_lru_table_unit #(
    parameter int ENTRIES = icmpd_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ip_protocol,
    input  logic [7:0]  i_icmp_kind,
    input  logic [31:0] i_source_address,
    input  logic        i_from_loopback,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_drop,
    output logic [1:0]  o_outcome,
    output logic [4:0]  o_slot,
    output logic [31:0] o_source_drops,
    output logic [31:0] o_total_drops
);
    import icmpd_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = IW + SLOT_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [31:0]   r_addr;
    logic [31:0]   r_total;
    logic [CW-1:0] r_used;
    logic [IW-1:0] r_iss_idx;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_stamp;
    logic          r_drop;
    logic [IW-1:0] r_slot;
    logic [31:0]   r_drops;
    t_outcome      r_outcome;

    logic             r_out_valid;
    logic             r_out_drop;
    t_outcome         r_out_outcome;
    logic [SLOT_W-1:0] r_out_slot;
    logic [31:0]      r_out_src;
    logic [31:0]      r_out_total;

    t_entry        rd_data;
    t_entry        wr_data;
    logic          in_acc;
    logic          is_echo;
    logic          hit;
    logic          last;
    logic          older;
    logic          full;
    logic          issuing;
    logic          out_free;
    logic [IW-1:0] victim_idx;
    logic [SW-1:0] slot_ext;

    icmpd_entry_ram #(
        .DEPTH (ENTRIES),
        .IW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_WRITE),
        .i_wr_idx  (r_slot),
        .i_wr_data (wr_data),
        .i_rd_idx  (r_iss_idx),
        .o_rd_data (rd_data)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_echo    = !i_from_loopback && (i_ip_protocol == PROTO_ICMP)
                        && (i_icmp_kind == KIND_ECHO_REQUEST);

    assign hit   = r_cmp_vld && (rd_data.address == r_addr);
    assign last  = r_cmp_vld && ((CW'(r_cmp_idx) + CW'(1)) == r_used);
    assign full  = (r_used == CW'(ENTRIES));
    // Strictly smaller stamp wins, so a tie keeps the lower index.
    assign older = (r_cmp_idx == '0) || (rd_data.stamp < r_best_stamp);
    assign victim_idx = older ? r_cmp_idx : r_best_idx;

    assign out_free = !r_out_valid || i_out_ready;
    assign wr_data  = '{address: r_addr, drops: r_drops, stamp: r_total};
    assign slot_ext = SW'(r_slot);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!is_echo) begin
                        n_state = ST_DONE;
                    end else if (r_used == '0) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (hit || last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign issuing = (r_state == ST_SEARCH) && (n_state == ST_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_used      <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= issuing;
            r_cmp_idx <= r_iss_idx;
            if (issuing && (r_iss_idx != IW'(ENTRIES - 1))) begin
                r_iss_idx <= r_iss_idx + IW'(1);
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_addr    <= i_source_address;
                        r_iss_idx <= '0;
                        r_drop    <= is_echo;
                        r_slot    <= '0;
                        if (!is_echo) begin
                            r_drops   <= '0;
                            r_outcome <= OUT_ACCEPT;
                        end else begin
                            r_total <= r_total + 32'd1;
                            if (r_used == '0) begin
                                r_drops   <= 32'd1;
                                r_outcome <= OUT_APPEND;
                                r_used    <= CW'(1);
                            end
                        end
                    end
                end
                ST_SEARCH: begin
                    if (r_cmp_vld) begin
                        if (older) begin
                            r_best_idx   <= r_cmp_idx;
                            r_best_stamp <= rd_data.stamp;
                        end
                        if (hit) begin
                            r_slot    <= r_cmp_idx;
                            r_drops   <= rd_data.drops + 32'd1;
                            r_outcome <= OUT_HIT;
                        end else if (last) begin
                            r_drops <= 32'd1;
                            if (full) begin
                                r_slot    <= victim_idx;
                                r_outcome <= OUT_REPLACE;
                            end else begin
                                r_slot    <= IW'(r_used);
                                r_outcome <= OUT_APPEND;
                                r_used    <= r_used + CW'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid   <= 1'b1;
                r_out_drop    <= r_drop;
                r_out_outcome <= r_outcome;
                r_out_slot    <= slot_ext[SLOT_W-1:0];
                r_out_src     <= r_drops;
                r_out_total   <= r_total;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drop         = r_out_drop;
    assign o_outcome      = r_out_outcome;
    assign o_slot         = r_out_slot;
    assign o_source_drops = r_out_src;
    assign o_total_drops  = r_out_total;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(ENTRIES))
        else $error("fill count exceeds table depth");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (CW'(r_slot) < r_used))
        else $error("table write outside filled rows");

    a_accept_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drop) |->
            ((o_outcome == OUT_ACCEPT) && (o_slot == '0) && (o_source_drops == '0)))
        else $error("accepted beat carries table fields");

    a_new_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_outcome == OUT_APPEND) || (o_outcome == OUT_REPLACE)))
            |-> (o_drop && (o_source_drops == 32'd1)))
        else $error("new entry beat with wrong drop count");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(in_acc) && $past(i_rst_n)) |->
            (r_total == ($past(r_total) + ($past(is_echo) ? 32'd1 : 32'd0))))
        else $error("running total not bumped by exactly the drop");
`endif

endmodule

// ===== verif/tb_icmp_echo_drop_source_lru_table_unit.sv =====
`timescale 1ns / 100ps

module tb_icmp_echo_drop_source_lru_table_unit;
    import icmpd_pkg::*;

    localparam int TBL_DEPTH  = ENTRIES_DEF;
    localparam int POOL_SIZE  = 40;
    localparam int STALL_PCT  = 6;
    localparam int HANG_LIMIT = 2000;
    localparam int DRAIN_WAIT = TBL_DEPTH + 8;

    typedef struct packed {
        logic        drop;
        t_outcome    outcome;
        logic [4:0]  slot;
        logic [31:0] source_drops;
        logic [31:0] total_drops;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_ip_protocol = '0;
    logic [7:0]  i_icmp_kind = '0;
    logic [31:0] i_source_address = '0;
    logic        i_from_loopback = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_drop;
    logic [1:0]  o_outcome;
    logic [4:0]  o_slot;
    logic [31:0] o_source_drops;
    logic [31:0] o_total_drops;

    // Shadow copy of the source table.
    logic [31:0] row_addr  [TBL_DEPTH];
    logic [31:0] row_drops [TBL_DEPTH];
    logic [31:0] row_stamp [TBL_DEPTH];
    int unsigned rows_used = 0;
    logic [31:0] drops_seen = '0;

    t_verdict    pending_verdicts[$];
    logic [31:0] hot_sources [POOL_SIZE];
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;

    icmp_echo_drop_source_lru_table_unit #(
        .ENTRIES(TBL_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_ip_protocol    (i_ip_protocol),
        .i_icmp_kind      (i_icmp_kind),
        .i_source_address (i_source_address),
        .i_from_loopback  (i_from_loopback),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drop           (o_drop),
        .o_outcome        (o_outcome),
        .o_slot           (o_slot),
        .o_source_drops   (o_source_drops),
        .o_total_drops    (o_total_drops)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_verdict predict_verdict(input logic [7:0] proto,
                                                 input logic [7:0] kind,
                                                 input logic [31:0] addr,
                                                 input logic loop);
        t_verdict v;
        int       found;
        int       victim;
        v.drop         = 1'b0;
        v.outcome      = OUT_ACCEPT;
        v.slot         = '0;
        v.source_drops = '0;
        v.total_drops  = drops_seen;
        if (loop || proto != PROTO_ICMP || kind != KIND_ECHO_REQUEST) begin
            return v;
        end
        drops_seen    = drops_seen + 32'd1;
        v.drop        = 1'b1;
        v.total_drops = drops_seen;
        found = -1;
        for (int i = 0; i < rows_used; i++) begin
            if (found < 0 && row_addr[i] == addr) begin
                found = i;
            end
        end
        if (found >= 0) begin
            row_drops[found] = row_drops[found] + 32'd1;
            row_stamp[found] = drops_seen;
            v.outcome        = OUT_HIT;
            v.slot           = 5'(found);
            v.source_drops   = row_drops[found];
        end else if (rows_used < TBL_DEPTH) begin
            row_addr[rows_used]  = addr;
            row_drops[rows_used] = 32'd1;
            row_stamp[rows_used] = drops_seen;
            v.outcome            = OUT_APPEND;
            v.slot               = 5'(rows_used);
            v.source_drops       = 32'd1;
            rows_used++;
        end else begin
            // Full table: evict the stalest stamp, lowest index on a tie.
            victim = 0;
            for (int i = 1; i < TBL_DEPTH; i++) begin
                if (row_stamp[i] < row_stamp[victim]) begin
                    victim = i;
                end
            end
            row_addr[victim]  = addr;
            row_drops[victim] = 32'd1;
            row_stamp[victim] = drops_seen;
            v.outcome         = OUT_REPLACE;
            v.slot            = 5'(victim);
            v.source_drops    = 32'd1;
        end
        return v;
    endfunction

    // Valid is only lowered for random stall gaps outside calm mode; otherwise back-to-back beats keep it high.
    task automatic send_packet(input logic [7:0] proto, input logic [7:0] kind,
                               input logic [31:0] addr, input logic loop);
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_ip_protocol    <= proto;
        i_icmp_kind      <= kind;
        i_source_address <= addr;
        i_from_loopback  <= loop;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_verdicts.push_back(predict_verdict(proto, kind, addr, loop));
    endtask

    task automatic send_echo(input logic [31:0] addr);
        send_packet(PROTO_ICMP, KIND_ECHO_REQUEST, addr, 1'b0);
    endtask

    // Traffic meant to pass through: wrong protocol, wrong type, or loopback, plus one fully random case.
    task automatic send_noise();
        logic [7:0] proto;
        logic [7:0] kind;
        case ($urandom_range(3))
            0: begin
                send_packet(8'($urandom), 8'($urandom), $urandom, 1'($urandom));
            end
            1: begin
                send_packet(PROTO_ICMP, KIND_ECHO_REQUEST,
                            hot_sources[$urandom_range(POOL_SIZE - 1)], 1'b1);
            end
            2: begin
                kind = 8'($urandom);
                if (kind == KIND_ECHO_REQUEST) kind = 8'd0;
                send_packet(PROTO_ICMP, kind, hot_sources[$urandom_range(POOL_SIZE - 1)],
                            1'($urandom));
            end
            default: begin
                proto = 8'($urandom);
                if (proto == PROTO_ICMP) proto = 8'd17;
                send_packet(proto, KIND_ECHO_REQUEST, $urandom, 1'($urandom));
            end
        endcase
    endtask

    task automatic test_accepted_packets();
        send_packet(8'd0, KIND_ECHO_REQUEST, 32'h0000_0000, 1'b0);
        send_packet(8'd255, KIND_ECHO_REQUEST, 32'hFFFF_FFFF, 1'b0);
        send_packet(PROTO_ICMP, 8'd0, 32'h0A00_0001, 1'b0);
        send_packet(PROTO_ICMP, 8'd255, 32'hC0A8_0101, 1'b0);
        send_packet(PROTO_ICMP, KIND_ECHO_REQUEST, 32'hFFFF_FFFF, 1'b1);
        send_packet(8'd17, 8'd255, 32'h7F00_0001, 1'b1);
    endtask

    task automatic test_append_and_hit();
        send_echo(32'h0000_0000);
        send_echo(32'hFFFF_FFFF);
        send_echo(32'h0000_0000);
        send_packet(PROTO_ICMP, KIND_ECHO_REQUEST, 32'h0000_0000, 1'b1);
        send_echo(32'hFFFF_FFFF);
        send_echo(32'h8000_0001);
        send_packet(PROTO_ICMP, 8'd0, 32'h8000_0001, 1'b0);
        send_echo(32'h0000_0000);
    endtask

    // More sources than table rows keeps the table full and forces evictions,
    // while a skewed pick gives some sources repeated hits.
    task automatic test_table_churn(input int beats);
        int pick;
        for (int i = 0; i < POOL_SIZE; i++) begin
            hot_sources[i] = $urandom;
        end
        hot_sources[0] = 32'h0000_0000;
        hot_sources[1] = 32'hFFFF_FFFF;
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(99) < 3) begin
                hot_sources[$urandom_range(POOL_SIZE - 1)] = $urandom;
            end
            if ($urandom_range(99) < 20) begin
                send_noise();
            end else begin
                pick = $urandom_range(1) ? $urandom_range(7) : $urandom_range(POOL_SIZE - 1);
                send_echo(hot_sources[pick]);
            end
        end
    endtask

    task automatic test_calm_traffic(input int beats);
        calm = 1'b1;
        test_table_churn(beats);
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing expected", results_seen);
                end
            end else begin
                want = pending_verdicts.pop_front();
                if (o_drop !== want.drop || o_outcome !== want.outcome
                        || o_slot !== want.slot || o_source_drops !== want.source_drops
                        || o_total_drops !== want.total_drops) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: exp drop=%0b outcome=%0d slot=%0d src=%0d tot=%0d",
                                 results_seen, want.drop, want.outcome, want.slot,
                                 want.source_drops, want.total_drops);
                        $display("           got drop=%0b outcome=%0d slot=%0d src=%0d tot=%0d",
                                 o_drop, o_outcome, o_slot, o_source_drops, o_total_drops);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_verdicts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_accepted_packets();
        test_append_and_hit();
        test_table_churn(1400);
        test_calm_traffic(300);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== icmp_echo_drop_source_lru_table_unit.f =====
src/icmpd_pkg.sv
src/icmpd_entry_ram.sv
src/icmp_echo_drop_source_lru_table_unit.sv
verif/tb_icmp_echo_drop_source_lru_table_unit.sv
